/* sv/owo_pkg.sv */
// Shared types and constants of the omni wheel odometry block.
`timescale 1ns / 1ps
`default_nettype none
package owo_pkg;

	localparam int CNT_W    = 32;  // encoder count
	localparam int SUM_W    = 34;  // sum of four wheel deltas
	localparam int MULA_W   = 34;
	localparam int MULB_W   = 32;
	localparam int PROD_W   = MULA_W + MULB_W;
	localparam int KC_W     = 31;
	localparam int DYAW_W   = 54;
	localparam int DMAG_W   = 50;
	localparam int YAW_W    = 56;
	localparam int MAG_W    = 55;
	localparam int POS_W    = 48;
	localparam int POSSUM_W = 52;
	localparam int HEAD_W   = 32;
	localparam int REM_W    = 31;
	localparam int RAW_W    = 32;  // remainder before the final correction, below 4 pi
	localparam int SNAP_W   = 29;
	localparam int MAG_SH   = 20;  // heading magnitude is below 2^54, top 34 bits feed the multiplier
	localparam int Q_SH     = 42;
	localparam int CFG_IDX_W = 2;

	localparam logic [MULB_W-1:0] SQRT2_QUARTER_Q32 = 32'd1518500250;
	localparam logic [SNAP_W-1:0] SNAP_RESET = 29'd70276134;
	localparam logic [REM_W-1:0]  TWO_PI_Q28 = 31'd1686629713;
	// floor(2^62 / TWO_PI_Q28), rounds down so the quotient estimate never overshoots
	localparam logic [MULB_W-1:0] RECIP_TWO_PI =
		MULB_W'((64'd1 << (MAG_SH + Q_SH)) / 64'(TWO_PI_Q28));
	localparam logic signed [YAW_W-1:0] HALF_PI_Q28       = 56'sd421657428;
	localparam logic signed [YAW_W-1:0] PI_Q28            = 56'sd843314857;
	localparam logic signed [YAW_W-1:0] THREE_HALF_PI_Q28 = 56'sd1264972285;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_MM_PER_COUNT  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_RAD_PER_COUNT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SNAP_WINDOW   = 2'd2;

	typedef enum logic [1:0] {
		QUAD_0,
		QUAD_90,
		QUAD_180,
		QUAD_270
	} quad_t;

	typedef enum logic [2:0] {
		MUL_KC,
		MUL_S,
		MUL_X,
		MUL_Y,
		MUL_Q,
		MUL_R
	} mul_sel_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SUM,
		ST_MAG,
		ST_MULS,
		ST_MULX,
		ST_MULY,
		ST_YAW,
		ST_SNAP,
		ST_POS,
		ST_MULR,
		ST_REM,
		ST_FIN
	} state_t;

	typedef struct packed {
		logic     s_ready;
		logic     ld_delta;
		logic     ld_sum;
		logic     ld_mag;
		logic     mul_en;
		mul_sel_t mul_sel;
		logic     ld_dyaw;
		logic     ld_dxm;
		logic     ld_yaw;
		logic     snap_en;
		logic     ld_pos;
		logic     ld_rem;
		logic     fin;
		quad_t    win;
	} ctl_t;

	// centre of each cardinal window, in test order
	function automatic logic signed [YAW_W-1:0] snap_centre(input quad_t q);
		logic signed [YAW_W-1:0] c;
		unique case (q)
			QUAD_0:   c = '0;
			QUAD_90:  c = HALF_PI_Q28;
			QUAD_180: c = PI_Q28;
			QUAD_270: c = THREE_HALF_PI_Q28;
			default:  c = '0;
		endcase
		return c;
	endfunction

endpackage
`default_nettype wire

/* sv/owo_mul.sv */
// Shared unsigned multiplier with registered product.
`timescale 1ns / 1ps
`default_nettype none
module owo_mul (
	input  wire                          clk,
	input  wire                          en,
	input  wire  [owo_pkg::MULA_W-1:0]   a,
	input  wire  [owo_pkg::MULB_W-1:0]   b,
	output logic [owo_pkg::PROD_W-1:0]   prod_q
);
	import owo_pkg::*;

	always_ff @(posedge clk) begin
		if (en) begin
			prod_q <= PROD_W'(a) * PROD_W'(b);
		end
	end

endmodule
`default_nettype wire

/* sv/owo_mod.sv */
// Heading wrap: two pi remainder from a reciprocal quotient estimate.
`timescale 1ns / 1ps
`default_nettype none
module owo_mod (
	input  wire                          clk,
	input  wire                          ld,
	input  wire  [owo_pkg::MAG_W-1:0]    mag,
	input  wire  [owo_pkg::MAG_W-1:0]    qprod,
	output logic [owo_pkg::REM_W-1:0]    rem
);
	import owo_pkg::*;

	logic [RAW_W-1:0] raw_q;

	// the quotient estimate is at most one short, so mag - q * 2pi is below 4 pi
	always_ff @(posedge clk) begin
		if (ld) begin
			raw_q <= RAW_W'(mag - qprod);
		end
	end

	assign rem = (raw_q >= RAW_W'(TWO_PI_Q28)) ? REM_W'(raw_q - RAW_W'(TWO_PI_Q28))
	                                           : raw_q[REM_W-1:0];

endmodule
`default_nettype wire

/* sv/owo_ctrl.sv */
// Sequencer of the odometry update.
`timescale 1ns / 1ps
`default_nettype none
module owo_ctrl (
	input  wire           clk,
	input  wire           arst_n,
	input  wire           s_valid,
	input  wire           snap_hit,
	input  wire           out_free,
	output owo_pkg::ctl_t ctl
);
	import owo_pkg::*;

	state_t state_q;
	state_t state_d;
	quad_t  win_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			win_q   <= QUAD_0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_SNAP && !snap_hit && win_q != QUAD_270) begin
				win_q <= quad_t'(win_q + 2'd1);
			end else begin
				win_q <= QUAD_0;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (s_valid) state_d = ST_SUM;
			ST_SUM:  state_d = ST_MAG;
			ST_MAG:  state_d = ST_MULS;
			ST_MULS: state_d = ST_MULX;
			ST_MULX: state_d = ST_MULY;
			ST_MULY: state_d = ST_YAW;
			ST_YAW:  state_d = ST_SNAP;
			ST_SNAP: if (snap_hit || win_q == QUAD_270) state_d = ST_POS;
			ST_POS:  state_d = ST_MULR;
			ST_MULR: state_d = ST_REM;
			ST_REM:  state_d = ST_FIN;
			ST_FIN:  if (out_free) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		ctl = '0;
		ctl.mul_sel = MUL_KC;
		ctl.win = win_q;
		unique case (state_q)
			ST_IDLE: begin
				ctl.s_ready  = 1'b1;
				ctl.ld_delta = s_valid;
			end
			ST_SUM: begin
				ctl.ld_sum  = 1'b1;
				ctl.mul_en  = 1'b1;
				ctl.mul_sel = MUL_KC;
			end
			ST_MAG:  ctl.ld_mag = 1'b1;
			ST_MULS: begin
				ctl.mul_en  = 1'b1;
				ctl.mul_sel = MUL_S;
			end
			ST_MULX: begin
				ctl.ld_dyaw = 1'b1;
				ctl.mul_en  = 1'b1;
				ctl.mul_sel = MUL_X;
			end
			ST_MULY: begin
				ctl.ld_dxm  = 1'b1;
				ctl.mul_en  = 1'b1;
				ctl.mul_sel = MUL_Y;
			end
			ST_YAW:  ctl.ld_yaw = 1'b1;
			ST_SNAP: ctl.snap_en = 1'b1;
			ST_POS: begin
				ctl.ld_pos  = 1'b1;
				ctl.mul_en  = 1'b1;
				ctl.mul_sel = MUL_Q;
			end
			ST_MULR: begin
				ctl.mul_en  = 1'b1;
				ctl.mul_sel = MUL_R;
			end
			ST_REM:  ctl.ld_rem = 1'b1;
			ST_FIN:  ctl.fin = out_free;
			default: ctl.s_ready = 1'b0;
		endcase
	end

endmodule
`default_nettype wire

/* sv/omni_wheel_odometry_top.sv */
// Four-wheel omni chassis odometry: top level with datapath.
//
// Input words on s_axis carry the four accumulated encoder counts; each accepted
// word yields one output word on m_axis with the updated map position, heading
// and the cardinal angle used to rotate the body step.
// Configuration is written through cfg_valid/cfg_index/cfg_data; the user must
// write it only while the block is idle, which the block does not enforce;
// cfg_ready is always high and unknown indexes are dropped. From input accept
// to output valid the sequencer runs the sum, magnitude and four passes through
// the shared 34x32 multiplier, the window tests, a position step that also starts
// the heading wrap, reciprocal quotient and subtract, and a step to correct the
// remainder and load the output. s_axis_tready is high only while the sequencer
// is idle, so a word is taken only after the previous one has been through.
// The output word sits in a register, so a new input word is taken while the
// previous result waits; if the receiver stalls past the next result, the
// sequencer holds in its last step until the output register frees.
// Reset clears the pose, the stored counts and the registers to their defaults
// (snap window fifteen degrees).
`timescale 1ns / 1ps
`default_nettype none
module omni_wheel_odometry_top (
	input  wire          clk,
	input  wire          arst_n,
	input  wire          s_axis_tvalid,
	output logic         s_axis_tready,
	// enc_total_0, enc_total_1, enc_total_2, enc_total_3
	input  wire  [127:0] s_axis_tdata,
	output logic         m_axis_tvalid,
	input  wire          m_axis_tready,
	// pos_x, pos_y, heading, quadrant, zero fill
	output logic [135:0] m_axis_tdata,
	input  wire          cfg_valid,
	output logic         cfg_ready,
	input  wire  [1:0]   cfg_index,
	input  wire  [31:0]  cfg_data
);
	import owo_pkg::*;

	ctl_t ctl;

	logic [CNT_W-1:0]  mm_per_count_q;
	logic [CNT_W-1:0]  rad_per_count_q;
	logic [SNAP_W-1:0] snap_window_q;

	logic [CNT_W-1:0]         last_q [4];
	logic signed [CNT_W-1:0]  d_q [4];
	logic signed [SUM_W-1:0]  sx_q, sy_q, ss_q;
	logic [SUM_W-1:0]         mx_q, my_q, ms_q;
	logic                     sgx_q, sgy_q, sgs_q;
	logic [KC_W-1:0]          kc_q;
	logic [DYAW_W-1:0]        dyawm_q;
	logic [DMAG_W-1:0]        dxm_q, dym_q;
	logic signed [YAW_W-1:0]  yaw_q;
	quad_t                    quad_q;
	logic                     ysign_q;
	logic signed [POS_W-1:0]  pose_x_q, pose_y_q;
	logic signed [HEAD_W-1:0] pose_h_q;

	logic                     out_valid_q;
	logic [POS_W-1:0]         out_x_q, out_y_q;
	logic [HEAD_W-1:0]        out_h_q;
	quad_t                    out_quad_q;

	logic [MULA_W-1:0] mul_a;
	logic [MULB_W-1:0] mul_b;
	logic [PROD_W-1:0] prod_q;
	logic [PROD_W-1:0] rnd_kc, rnd_yaw, rnd_d;

	logic signed [YAW_W-1:0]    yaw_d, diff, wv, yaw_abs;
	logic                       snap_hit;
	logic [DMAG_W-1:0]          px_m, py_m;
	logic                       px_neg, py_neg;
	logic signed [POSSUM_W-1:0] px_sum, py_sum;
	logic [REM_W-1:0]           mod_rem;
	logic signed [HEAD_W-1:0]   rem_s, head_d;
	logic                       out_free;

	function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [POSSUM_W-1:0] v);
		logic signed [POS_W-1:0] r;
		if (v[POSSUM_W-1:POS_W-1] == '0 || v[POSSUM_W-1:POS_W-1] == '1) begin
			r = v[POS_W-1:0];
		end else if (v[POSSUM_W-1]) begin
			r = {1'b1, {(POS_W-1){1'b0}}};
		end else begin
			r = {1'b0, {(POS_W-1){1'b1}}};
		end
		return r;
	endfunction

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mm_per_count_q  <= '0;
			rad_per_count_q <= '0;
			snap_window_q   <= SNAP_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_MM_PER_COUNT:  mm_per_count_q  <= cfg_data;
				CFG_RAD_PER_COUNT: rad_per_count_q <= cfg_data;
				CFG_SNAP_WINDOW:   snap_window_q   <= cfg_data[SNAP_W-1:0];
				default:           snap_window_q   <= snap_window_q;
			endcase
		end
	end

	owo_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_valid  (s_axis_tvalid),
		.snap_hit (snap_hit),
		.out_free (out_free),
		.ctl      (ctl)
	);

	assign s_axis_tready = ctl.s_ready;
	assign out_free = !out_valid_q || m_axis_tready;

	// wheel deltas and stored counts
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 4; i++) begin
				last_q[i] <= '0;
			end
		end else if (ctl.ld_delta) begin
			for (int i = 0; i < 4; i++) begin
				last_q[i] <= s_axis_tdata[i*CNT_W +: CNT_W];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.ld_delta) begin
			for (int i = 0; i < 4; i++) begin
				d_q[i] <= s_axis_tdata[i*CNT_W +: CNT_W] - last_q[i];
			end
		end
		if (ctl.ld_sum) begin
			sx_q <= SUM_W'(d_q[0]) + SUM_W'(d_q[1]) - SUM_W'(d_q[2]) - SUM_W'(d_q[3]);
			sy_q <= SUM_W'(d_q[1]) + SUM_W'(d_q[2]) - SUM_W'(d_q[0]) - SUM_W'(d_q[3]);
			ss_q <= SUM_W'(d_q[0]) + SUM_W'(d_q[1]) + SUM_W'(d_q[2]) + SUM_W'(d_q[3]);
		end
		if (ctl.ld_mag) begin
			mx_q  <= sx_q[SUM_W-1] ? SUM_W'(-sx_q) : SUM_W'(sx_q);
			my_q  <= sy_q[SUM_W-1] ? SUM_W'(-sy_q) : SUM_W'(sy_q);
			ms_q  <= ss_q[SUM_W-1] ? SUM_W'(-ss_q) : SUM_W'(ss_q);
			sgx_q <= sx_q[SUM_W-1];
			sgy_q <= sy_q[SUM_W-1];
			sgs_q <= ss_q[SUM_W-1];
			kc_q  <= rnd_kc[KC_W+31:32];
		end
		if (ctl.ld_dyaw) begin
			dyawm_q <= rnd_yaw[PROD_W-1:12];
		end
		if (ctl.ld_dxm) begin
			dxm_q <= rnd_d[PROD_W-1:16];
		end
		if (ctl.ld_yaw) begin
			dym_q <= rnd_d[PROD_W-1:16];
			yaw_q <= yaw_d;
		end
		if (ctl.snap_en) begin
			quad_q <= snap_hit ? ctl.win : QUAD_0;
		end
		if (ctl.ld_pos) begin
			ysign_q <= yaw_q[YAW_W-1];
		end
	end

	// shared multiplier operands
	always_comb begin
		unique case (ctl.mul_sel)
			MUL_KC: begin
				mul_a = MULA_W'(mm_per_count_q);
				mul_b = SQRT2_QUARTER_Q32;
			end
			MUL_S: begin
				mul_a = ms_q;
				mul_b = rad_per_count_q;
			end
			MUL_X: begin
				mul_a = mx_q;
				mul_b = MULB_W'(kc_q);
			end
			MUL_Y: begin
				mul_a = my_q;
				mul_b = MULB_W'(kc_q);
			end
			// quotient estimate of the heading magnitude over two pi
			MUL_Q: begin
				mul_a = yaw_abs[MAG_SH +: MULA_W];
				mul_b = RECIP_TWO_PI;
			end
			MUL_R: begin
				mul_a = MULA_W'(prod_q[PROD_W-1:Q_SH]);
				mul_b = MULB_W'(TWO_PI_Q28);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	owo_mul u_mul (
		.clk    (clk),
		.en     (ctl.mul_en),
		.a      (mul_a),
		.b      (mul_b),
		.prod_q (prod_q)
	);

	// round half away from zero on magnitudes
	assign rnd_kc  = prod_q + PROD_W'(64'h8000_0000);
	assign rnd_yaw = prod_q + PROD_W'(2048);
	assign rnd_d   = prod_q + PROD_W'(32768);

	always_comb begin
		if (sgs_q) begin
			yaw_d = YAW_W'(pose_h_q) + $signed(YAW_W'(dyawm_q));
		end else begin
			yaw_d = YAW_W'(pose_h_q) - $signed(YAW_W'(dyawm_q));
		end
	end

	// one window per cycle, strict bounds
	assign diff     = yaw_q - snap_centre(ctl.win);
	assign wv       = $signed(YAW_W'(snap_window_q));
	assign snap_hit = (diff < wv) && (diff > -wv);

	// rotation by swap and negation
	always_comb begin
		unique case (quad_q)
			QUAD_90: begin
				px_m = dym_q; px_neg = !sgy_q;
				py_m = dxm_q; py_neg = sgx_q;
			end
			QUAD_180: begin
				px_m = dxm_q; px_neg = !sgx_q;
				py_m = dym_q; py_neg = !sgy_q;
			end
			QUAD_270: begin
				px_m = dym_q; px_neg = sgy_q;
				py_m = dxm_q; py_neg = !sgx_q;
			end
			default: begin
				px_m = dxm_q; px_neg = sgx_q;
				py_m = dym_q; py_neg = sgy_q;
			end
		endcase
		px_sum = px_neg ? POSSUM_W'(pose_x_q) - $signed(POSSUM_W'(px_m))
		                : POSSUM_W'(pose_x_q) + $signed(POSSUM_W'(px_m));
		py_sum = py_neg ? POSSUM_W'(pose_y_q) - $signed(POSSUM_W'(py_m))
		                : POSSUM_W'(pose_y_q) + $signed(POSSUM_W'(py_m));
	end

	assign yaw_abs = yaw_q[YAW_W-1] ? -yaw_q : yaw_q;

	owo_mod u_mod (
		.clk   (clk),
		.ld    (ctl.ld_rem),
		.mag   (yaw_abs[MAG_W-1:0]),
		.qprod (prod_q[MAG_W-1:0]),
		.rem   (mod_rem)
	);

	// remainder takes the sign of the unwrapped heading
	assign rem_s  = $signed(HEAD_W'(mod_rem));
	assign head_d = ysign_q ? -rem_s : rem_s;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pose_x_q <= '0;
			pose_y_q <= '0;
			pose_h_q <= '0;
		end else begin
			if (ctl.ld_pos) begin
				pose_x_q <= sat_pos(px_sum);
				pose_y_q <= sat_pos(py_sum);
			end
			if (ctl.fin) begin
				pose_h_q <= head_d;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.fin) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.fin) begin
			out_x_q    <= pose_x_q;
			out_y_q    <= pose_y_q;
			out_h_q    <= head_d;
			out_quad_q <= quad_q;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {6'b0, out_quad_q, out_h_q, out_y_q, out_x_q};

endmodule
`default_nettype wire
